// File: rtl/core/rcmp_pkg.sv
// Shared types and constants of the RAMDAC color map port.
`default_nettype none

package rcmp_pkg;

   localparam int OFFSET_W = 8;
   localparam int SIZE_W   = 3;
   localparam int WDATA_W  = 16;
   localparam int RDATA_W  = 8;
   localparam int INDEX_W  = 8;
   localparam int COLOR_W  = 24;

   localparam logic [OFFSET_W-1:0] HIGH_OFFSET = 8'h20;
   localparam logic [RDATA_W-1:0]  CMD_VALUE   = 8'hff;

   // Register word within a window, taken from offset bits 3:2.
   localparam logic [1:0] WORD_WADDR = 2'd0;
   localparam logic [1:0] WORD_DATA  = 2'd1;
   localparam logic [1:0] WORD_CMD   = 2'd2;
   localparam logic [1:0] WORD_RADDR = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;

   // Position of the next byte within a three-byte color transfer.
   localparam logic [1:0] BYTE_FIRST  = 2'd0;
   localparam logic [1:0] BYTE_SECOND = 2'd1;
   localparam logic [1:0] BYTE_THIRD  = 2'd2;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                is_write;
      logic [SIZE_W-1:0]   access_size;
      logic [WDATA_W-1:0]  write_data;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic [RDATA_W-1:0] read_data;
      logic               entry_changed;
      logic               changed_window;
      logic [INDEX_W-1:0] changed_index;
      logic [COLOR_W-1:0] changed_color;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic issue_read;
      logic mod_step1;
      logic mod_step2;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_mod;
      logic needs_mem;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/rcmp_req_if.sv
// Request channel of the color map port: valid, ready and one bus access.
`default_nettype none

interface rcmp_req_if;
   logic                               valid;
   logic                               ready;
   logic [rcmp_pkg::OFFSET_W-1:0]      offset;
   logic                               is_write;
   logic [rcmp_pkg::SIZE_W-1:0]        access_size;
   logic [rcmp_pkg::WDATA_W-1:0]       write_data;

   modport source (output valid, offset, is_write, access_size, write_data, input ready);
   modport sink   (input valid, offset, is_write, access_size, write_data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcmp_rsp_if.sv
// Response channel of the color map port: valid, ready and one access result.
`default_nettype none

interface rcmp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [rcmp_pkg::RDATA_W-1:0]  read_data;
   logic                          entry_changed;
   logic                          changed_window;
   logic [rcmp_pkg::INDEX_W-1:0]  changed_index;
   logic [rcmp_pkg::COLOR_W-1:0]  changed_color;

   modport source (output valid, ok, read_data, entry_changed, changed_window,
                   changed_index, changed_color, input ready);
   modport sink   (input valid, ok, read_data, entry_changed, changed_window,
                   changed_index, changed_color, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rcmp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/rcmp_ctrl.sv
// Sequencer of the color map port: handshakes and datapath commands.
`default_nettype none

module rcmp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire rcmp_pkg::dp_status_type status,
   output rcmp_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_REM  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_MEM  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The response register may be reloaded when empty or drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.needs_mod) begin
               cmd.mod_step1 = 1'b1;
               state_in      = ST_REM;
            end else if (status.needs_mem) begin
               cmd.issue_read = 1'b1;
               state_in       = ST_MEM;
            end else if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_REM: begin
            cmd.mod_step2 = 1'b1;
            state_in      = ST_FIX;
         end
         ST_FIX, ST_MEM: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rcmp_dpath.sv
// Datapath of the color map port: window registers, color tables and result word.
`default_nettype none

module rcmp_dpath #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int OVERLAY_ENTRIES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rcmp_pkg::req_word_type req_word,
   input  wire rcmp_pkg::dp_cmd_type   cmd,
   output rcmp_pkg::dp_status_type     status,
   output rcmp_pkg::rsp_word_type      rsp_word
);

   localparam int PAW = $clog2(PALETTE_ENTRIES);
   localparam int OAW = $clog2(OVERLAY_ENTRIES);
   localparam logic [9:0]  PAL_N     = 10'(PALETTE_ENTRIES);
   localparam logic [9:0]  OVL_N     = 10'(OVERLAY_ENTRIES);
   localparam logic [7:0]  PAL_LAST  = 8'(PALETTE_ENTRIES - 1);
   localparam logic [7:0]  OVL_LAST  = 8'(OVERLAY_ENTRIES - 1);
   // Truncated reciprocals: the quotient estimate is low by at most one.
   localparam logic [23:0] PAL_RECIP = 24'((1 << 24) / PALETTE_ENTRIES);
   localparam logic [23:0] OVL_RECIP = 24'((1 << 24) / OVERLAY_ENTRIES);

   rcmp_pkg::req_word_type item_ff;
   rcmp_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [1:0][7:0]  waddr_ff, waddr_in;
   logic [1:0][7:0]  raddr_ff, raddr_in;
   logic [1:0][1:0]  wcnt_ff, wcnt_in;
   logic [1:0][1:0]  rcnt_ff, rcnt_in;
   logic [1:0][15:0] wbyte_ff, wbyte_in;
   logic [1:0][15:0] rbyte_ff, rbyte_in;
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff, pal_vld_in;
   logic [OVERLAY_ENTRIES-1:0] ovl_vld_ff, ovl_vld_in;
   logic [15:0] quot_ff, quot_in;
   logic [9:0]  rem_ff, rem_in;

   logic        size_ok, ok_base, high, in_window, wr, win, color_done;
   logic [1:0]  word;
   logic [15:0] val;
   logic [9:0]  n_sel, mod_res;
   logic [7:0]  last_sel, tbl_idx, next_idx, mod_idx;
   logic [23:0] recip_sel, color, stored, pal_q, ovl_q;
   logic [39:0] prod;
   logic [25:0] qn, diff;
   logic        pal_we, ovl_we, pal_re, ovl_re;

   // Decode of the captured access.
   assign wr      = item_ff.is_write;
   assign size_ok = (item_ff.access_size == rcmp_pkg::SIZE_BYTE) ||
                    (item_ff.access_size == rcmp_pkg::SIZE_HALF);
   assign val     = (item_ff.access_size == rcmp_pkg::SIZE_BYTE) ?
                    {8'h00, item_ff.write_data[7:0]} : item_ff.write_data;
   assign ok_base   = size_ok && (item_ff.offset[1:0] == 2'b00);
   assign high      = item_ff.offset >= rcmp_pkg::HIGH_OFFSET;
   assign in_window = ok_base && !high;
   assign win       = item_ff.offset[4];
   assign word      = item_ff.offset[3:2];

   assign n_sel     = win ? OVL_N : PAL_N;
   assign last_sel  = win ? OVL_LAST : PAL_LAST;
   assign recip_sel = win ? OVL_RECIP : PAL_RECIP;

   assign status.needs_mod = in_window && wr &&
                             (word == rcmp_pkg::WORD_WADDR || word == rcmp_pkg::WORD_RADDR);
   assign status.needs_mem = in_window && (word == rcmp_pkg::WORD_DATA) &&
                             (wr ? (wcnt_ff[win] == rcmp_pkg::BYTE_THIRD)
                                 : (rcnt_ff[win] == rcmp_pkg::BYTE_FIRST));

   // Address writes keep the value modulo the table size.
   assign prod    = 40'(val) * 40'(recip_sel);
   assign quot_in = prod[39:24];
   assign qn      = 26'(quot_ff) * 26'(n_sel);
   assign diff    = 26'(val) - qn;
   assign rem_in  = diff[9:0];
   assign mod_res = (rem_ff >= n_sel) ? (rem_ff - n_sel) : rem_ff;
   assign mod_idx = mod_res[7:0];

   // Color writes use the write address, color reads the read address.
   assign tbl_idx  = wr ? waddr_ff[win] : raddr_ff[win];
   assign next_idx = (tbl_idx == last_sel) ? 8'h00 : (tbl_idx + 8'd1);
   assign color    = {val[7:0], wbyte_ff[win][15:8], wbyte_ff[win][7:0]};
   assign stored   = win ? (ovl_vld_ff[tbl_idx[OAW-1:0]] ? ovl_q : 24'h000000)
                         : (pal_vld_ff[tbl_idx[PAW-1:0]] ? pal_q : 24'h000000);
   assign color_done = in_window && wr && (word == rcmp_pkg::WORD_DATA) &&
                       (wcnt_ff[win] == rcmp_pkg::BYTE_THIRD);

   assign pal_re = cmd.issue_read && !win;
   assign ovl_re = cmd.issue_read && win;
   assign pal_we = cmd.finish && color_done && !win;
   assign ovl_we = cmd.finish && color_done && win;

   rcmp_ram #(.WIDTH(rcmp_pkg::COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (tbl_idx[PAW-1:0]),
      .wr_data (color),
      .rd_en   (pal_re),
      .rd_addr (tbl_idx[PAW-1:0]),
      .rd_data (pal_q)
   );

   rcmp_ram #(.WIDTH(rcmp_pkg::COLOR_W), .DEPTH(OVERLAY_ENTRIES)) u_ovl_ram (
      .clock   (clock),
      .wr_en   (ovl_we),
      .wr_addr (tbl_idx[OAW-1:0]),
      .wr_data (color),
      .rd_en   (ovl_re),
      .rd_addr (tbl_idx[OAW-1:0]),
      .rd_data (ovl_q)
   );

   always_comb begin
      waddr_in   = waddr_ff;
      raddr_in   = raddr_ff;
      wcnt_in    = wcnt_ff;
      rcnt_in    = rcnt_ff;
      wbyte_in   = wbyte_ff;
      rbyte_in   = rbyte_ff;
      pal_vld_in = pal_vld_ff;
      ovl_vld_in = ovl_vld_ff;
      rsp_in     = '0;
      rsp_in.ok  = ok_base && (!high || wr);
      if (in_window) begin
         unique case (word)
            rcmp_pkg::WORD_WADDR: begin
               if (wr) begin
                  waddr_in[win] = mod_idx;
               end else begin
                  rsp_in.read_data = waddr_ff[win];
               end
            end
            rcmp_pkg::WORD_DATA: begin
               if (wr) begin
                  if (wcnt_ff[win] == rcmp_pkg::BYTE_THIRD) begin
                     wcnt_in[win]  = rcmp_pkg::BYTE_FIRST;
                     waddr_in[win] = next_idx;
                     if (win) begin
                        ovl_vld_in[tbl_idx[OAW-1:0]] = 1'b1;
                     end else begin
                        pal_vld_in[tbl_idx[PAW-1:0]] = 1'b1;
                     end
                     if (color != stored) begin
                        rsp_in.entry_changed  = 1'b1;
                        rsp_in.changed_window = win;
                        rsp_in.changed_index  = tbl_idx;
                        rsp_in.changed_color  = color;
                     end
                  end else if (wcnt_ff[win] == rcmp_pkg::BYTE_FIRST) begin
                     wbyte_in[win][7:0] = val[7:0];
                     wcnt_in[win]       = rcmp_pkg::BYTE_SECOND;
                  end else begin
                     wbyte_in[win][15:8] = val[7:0];
                     wcnt_in[win]        = rcmp_pkg::BYTE_THIRD;
                  end
               end else begin
                  if (rcnt_ff[win] == rcmp_pkg::BYTE_FIRST) begin
                     // The first byte comes from the table; the rest waits here.
                     rsp_in.read_data = stored[7:0];
                     rbyte_in[win]    = stored[23:8];
                     rcnt_in[win]     = rcmp_pkg::BYTE_SECOND;
                  end else if (rcnt_ff[win] == rcmp_pkg::BYTE_SECOND) begin
                     rsp_in.read_data = rbyte_ff[win][7:0];
                     rcnt_in[win]     = rcmp_pkg::BYTE_THIRD;
                  end else begin
                     rsp_in.read_data = rbyte_ff[win][15:8];
                     rcnt_in[win]     = rcmp_pkg::BYTE_FIRST;
                     raddr_in[win]    = next_idx;
                  end
               end
            end
            rcmp_pkg::WORD_CMD: begin
               if (wr) begin
                  if (val != {8'h00, rcmp_pkg::CMD_VALUE}) begin
                     rsp_in.ok = 1'b0;
                  end
               end else begin
                  rsp_in.read_data = rcmp_pkg::CMD_VALUE;
               end
            end
            rcmp_pkg::WORD_RADDR: begin
               if (wr) begin
                  raddr_in[win] = mod_idx;
               end else begin
                  rsp_in.read_data = raddr_ff[win];
               end
            end
            default: begin
               rsp_in.ok = 1'b0;
            end
         endcase
      end
      if (!rsp_in.ok || wr) begin
         rsp_in.read_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.mod_step1) begin
         quot_ff <= quot_in;
      end
      if (cmd.mod_step2) begin
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         rsp_ff   <= rsp_in;
         wbyte_ff <= wbyte_in;
         rbyte_ff <= rbyte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waddr_ff   <= '0;
         raddr_ff   <= '0;
         wcnt_ff    <= {rcmp_pkg::BYTE_FIRST, rcmp_pkg::BYTE_FIRST};
         rcnt_ff    <= {rcmp_pkg::BYTE_FIRST, rcmp_pkg::BYTE_FIRST};
         pal_vld_ff <= '0;
         ovl_vld_ff <= '0;
      end else if (cmd.finish) begin
         waddr_ff   <= waddr_in;
         raddr_ff   <= raddr_in;
         wcnt_ff    <= wcnt_in;
         rcnt_ff    <= rcnt_in;
         pal_vld_ff <= pal_vld_in;
         ovl_vld_ff <= ovl_vld_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/ramdac_color_map_port_core.sv
// RAMDAC color map port: bus access words in, one result word out for each.
// The req channel carries one bus access per word (offset, direction, size,
// write data); the rsp channel returns one word per access with the ok flag,
// read data and a report of each entry a color write changes. Both channels
// use a valid/ready handshake; a word moves when both are high.
// Two windows (palette and overlay) each hold a write address, a read
// address and a data port; three byte writes store one color and three
// byte reads return one, low byte first. Color tables live in RAMs with a
// per-entry valid bit, so after reset every entry reads as zero at once.
// Timing: an access is taken when the sequencer is idle. Register accesses
// go from acceptance straight to their finish step, color accesses that
// touch a table first pass a RAM read state, and address writes first pass
// the two multiply steps of the modulo unit. The result is registered and
// valid in the cycle after its finish step. Results go through an output
// register, so a new access can be taken while the previous result still
// waits; if the receiver stalls with a result pending, the next one holds
// in the sequencer until the register frees. Reset empties the output
// register and clears all addresses, byte counters and table valid bits.
`default_nettype none

module ramdac_color_map_port_core #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int OVERLAY_ENTRIES = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   rcmp_req_if.sink   req_port,
   rcmp_rsp_if.source rsp_port
);

   rcmp_pkg::req_word_type  req_word;
   rcmp_pkg::rsp_word_type  rsp_word;
   rcmp_pkg::dp_cmd_type    dp_cmd;
   rcmp_pkg::dp_status_type dp_status;

   assign req_word.offset      = req_port.offset;
   assign req_word.is_write    = req_port.is_write;
   assign req_word.access_size = req_port.access_size;
   assign req_word.write_data  = req_port.write_data;

   rcmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   rcmp_dpath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .OVERLAY_ENTRIES (OVERLAY_ENTRIES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (dp_cmd),
      .status   (dp_status),
      .rsp_word (rsp_word)
   );

   assign rsp_port.ok             = rsp_word.ok;
   assign rsp_port.read_data      = rsp_word.read_data;
   assign rsp_port.entry_changed  = rsp_word.entry_changed;
   assign rsp_port.changed_window = rsp_word.changed_window;
   assign rsp_port.changed_index  = rsp_word.changed_index;
   assign rsp_port.changed_color  = rsp_word.changed_color;

   // A result is never written over one that has not been taken.
   a_finish_free : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |-> (!rsp_port.valid || rsp_port.ready))
      else $error("result loaded while the output register was full");

   // Only one access is in flight at a time.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("access taken while another was in flight");

   // A finished access shows up on the response channel next cycle.
   a_finish_shows : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |=> rsp_port.valid)
      else $error("finished access did not raise rsp valid");

   // A change report only comes from an accepted write.
   a_change_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.entry_changed) |-> rsp_port.ok)
      else $error("change report on a rejected access");

endmodule

`default_nettype wire

// File: tb/ramdac_color_map_port_core_tb.sv
// Self-checking testbench of the RAMDAC color map port: bus accesses checked by a scoreboard.
`default_nettype none

module ramdac_color_map_port_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PALETTE_ENTRIES = 256;
   localparam int OVERLAY_ENTRIES = 16;
   localparam int RANDOM_WORDS    = 1300;
   localparam int DRAIN_EVERY     = 300;
   localparam int TAIL_CYCLES     = 8;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int MAX_REPORTS     = 10;
   localparam bit WIN_PALETTE     = 1'b0;
   localparam bit WIN_OVERLAY     = 1'b1;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   class color_map_scoreboard;
      bit [rcmp_pkg::COLOR_W-1:0] color_table [2][2**rcmp_pkg::INDEX_W];
      bit [rcmp_pkg::INDEX_W-1:0] wr_addr [2];
      bit [rcmp_pkg::INDEX_W-1:0] rd_addr [2];
      bit [1:0]                   wr_count [2];
      bit [1:0]                   rd_count [2];
      bit [rcmp_pkg::COLOR_W-1:0] wr_color [2];
      bit [rcmp_pkg::COLOR_W-1:0] rd_color [2];
      rcmp_pkg::rsp_word_type     expected_q [$];
      int mismatches, results, accesses, bus_errors, changes, read_bytes;

      function int pending();
         return expected_q.size();
      endfunction

      // Works out the result word of one accepted access and queues it.
      function void note_access(rcmp_pkg::req_word_type a);
         rcmp_pkg::rsp_word_type r;
         logic [rcmp_pkg::WDATA_W-1:0] v;
         bit w;
         int unsigned n;
         r = '0;
         r.ok = 1'b1;
         v = '0;
         case (a.access_size)
            rcmp_pkg::SIZE_BYTE: v = {8'h00, a.write_data[7:0]};
            rcmp_pkg::SIZE_HALF: v = a.write_data;
            default:             r.ok = 1'b0;
         endcase
         if (r.ok && a.offset[1:0] != 2'b00)
            r.ok = 1'b0;
         if (r.ok && a.offset >= rcmp_pkg::HIGH_OFFSET) begin
            r.ok = a.is_write;
         end else if (r.ok) begin
            w = a.offset[4];
            n = w ? OVERLAY_ENTRIES : PALETTE_ENTRIES;
            case (a.offset[3:2])
               rcmp_pkg::WORD_WADDR: begin
                  if (a.is_write)
                     wr_addr[w] = 8'(v % n);
                  else
                     r.read_data = wr_addr[w];
               end
               rcmp_pkg::WORD_DATA: begin
                  if (a.is_write) begin
                     // Bytes enter at the top, so after three the first one sits lowest.
                     wr_color[w] = {v[7:0], wr_color[w][rcmp_pkg::COLOR_W-1:8]};
                     if (wr_count[w] == rcmp_pkg::BYTE_THIRD) begin
                        wr_count[w] = rcmp_pkg::BYTE_FIRST;
                        if (color_table[w][wr_addr[w]] != wr_color[w]) begin
                           r.entry_changed  = 1'b1;
                           r.changed_window = w;
                           r.changed_index  = wr_addr[w];
                           r.changed_color  = wr_color[w];
                           color_table[w][wr_addr[w]] = wr_color[w];
                        end
                        wr_addr[w] = 8'((wr_addr[w] + 1) % n);
                     end else begin
                        wr_count[w]++;
                     end
                  end else begin
                     // The color is latched on the first byte of a read transfer.
                     if (rd_count[w] == rcmp_pkg::BYTE_FIRST)
                        rd_color[w] = color_table[w][rd_addr[w]];
                     r.read_data = rd_color[w][8*rd_count[w] +: 8];
                     read_bytes++;
                     if (rd_count[w] == rcmp_pkg::BYTE_THIRD) begin
                        rd_count[w] = rcmp_pkg::BYTE_FIRST;
                        rd_addr[w] = 8'((rd_addr[w] + 1) % n);
                     end else begin
                        rd_count[w]++;
                     end
                  end
               end
               rcmp_pkg::WORD_CMD: begin
                  if (a.is_write) begin
                     if (v != {8'h00, rcmp_pkg::CMD_VALUE})
                        r.ok = 1'b0;
                  end else begin
                     r.read_data = rcmp_pkg::CMD_VALUE;
                  end
               end
               rcmp_pkg::WORD_RADDR: begin
                  if (a.is_write)
                     rd_addr[w] = 8'(v % n);
                  else
                     r.read_data = rd_addr[w];
               end
            endcase
         end
         if (!r.ok || a.is_write)
            r.read_data = '0;
         accesses++;
         if (!r.ok)
            bus_errors++;
         if (r.entry_changed)
            changes++;
         expected_q.push_back(r);
      endfunction

      function void check_result(rcmp_pkg::rsp_word_type got);
         rcmp_pkg::rsp_word_type want;
         results++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Result word %0d arrived with no access outstanding", results);
            return;
         end
         want = expected_q.pop_front();
         if (got.ok !== want.ok || got.read_data !== want.read_data ||
             got.entry_changed !== want.entry_changed ||
             got.changed_window !== want.changed_window ||
             got.changed_index !== want.changed_index ||
             got.changed_color !== want.changed_color) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display({"Result word %0d: expected ok %0b data %02h chg %0b",
                         " win %0b idx %02h col %06h"},
                        results, want.ok, want.read_data, want.entry_changed,
                        want.changed_window, want.changed_index, want.changed_color);
               $display({"                      got ok %0b data %02h chg %0b",
                         " win %0b idx %02h col %06h"},
                        got.ok, got.read_data, got.entry_changed,
                        got.changed_window, got.changed_index, got.changed_color);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   words_sent = 0;
   int   ignored_words = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [rcmp_pkg::INDEX_W-1:0] last_upload [2];
   color_map_scoreboard sb = new();

   rcmp_req_if req_if ();
   rcmp_rsp_if rsp_if ();

   ramdac_color_map_port_core #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES),
      .OVERLAY_ENTRIES(OVERLAY_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_if),
      .rsp_port(rsp_if)
   );

   always #1ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Results are checked before the access of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.ok, rsp_if.read_data, rsp_if.entry_changed,
                             rsp_if.changed_window, rsp_if.changed_index,
                             rsp_if.changed_color});
         if (req_if.valid && req_if.ready)
            sb.note_access({req_if.offset, req_if.is_write, req_if.access_size,
                            req_if.write_data});
      end
   end

   // The receiver periodically redraws its stall behavior at random from four modes.
   always @(posedge clock) begin
      if (cycle_count % 160 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_if.ready <= 1'b1;
         STALL_RANDOM:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_if.ready <= ((cycle_count % 7) < 3);
         default:        rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out with %0d result words outstanding", sb.pending());
      $display("ramdac_color_map_port_core_tb: FAIL");
      $finish;
   end

   function automatic logic [rcmp_pkg::OFFSET_W-1:0] reg_offset(bit w, logic [1:0] word);
      return {3'b000, w, word, 2'b00};
   endfunction

   function automatic logic [rcmp_pkg::SIZE_W-1:0] pick_size();
      return $urandom_range(0, 1) ? rcmp_pkg::SIZE_HALF : rcmp_pkg::SIZE_BYTE;
   endfunction

   // Puts a color byte under a random upper byte, which a byte access ignores.
   function automatic logic [rcmp_pkg::WDATA_W-1:0] with_byte(logic [7:0] b);
      return {8'($urandom), b};
   endfunction

   function automatic logic [rcmp_pkg::COLOR_W-1:0] rand_color();
      logic [rcmp_pkg::COLOR_W-1:0] c;
      c = 24'($urandom);
      case ($urandom_range(0, 5))
         0: c = '0;
         1: c = '1;
         2: c[15:8] = 8'hff;
         default: ;
      endcase
      return c;
   endfunction

   // Sends one word; the sender runs in bursts with random gaps between them.
   task automatic send_access(logic [rcmp_pkg::OFFSET_W-1:0] off, logic wr,
                              logic [rcmp_pkg::SIZE_W-1:0] size,
                              logic [rcmp_pkg::WDATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (wr && off == reg_offset(off[4], rcmp_pkg::WORD_WADDR))
         last_upload[off[4]] = data[rcmp_pkg::INDEX_W-1:0];
      req_if.valid       <= 1'b1;
      req_if.offset      <= off;
      req_if.is_write    <= wr;
      req_if.access_size <= size;
      req_if.write_data  <= data;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int pick, i, rep, next_drain;
      bit w, wr;
      logic [1:0] word;
      logic [rcmp_pkg::COLOR_W-1:0] c;
      logic [rcmp_pkg::WDATA_W-1:0] d;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.offset      <= '0;
      req_if.is_write    <= 1'b0;
      req_if.access_size <= '0;
      req_if.write_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Address writes keep the value modulo the table size.
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_WADDR), 1'b1, rcmp_pkg::SIZE_HALF,
                  16'h01fe);
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_WADDR), 1'b0, rcmp_pkg::SIZE_BYTE,
                  16'h0000);
      // The first upload changes the entry; the same color again leaves it unchanged.
      for (rep = 0; rep < 2; rep++) begin
         send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_WADDR), 1'b1,
                     rcmp_pkg::SIZE_BYTE, 16'hfffe);
         send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_DATA), 1'b1,
                     rcmp_pkg::SIZE_HALF, 16'hff11);
         send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_DATA), 1'b1,
                     rcmp_pkg::SIZE_BYTE, 16'h0022);
         send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_DATA), 1'b1,
                     rcmp_pkg::SIZE_BYTE, 16'hffff);
      end
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_RADDR), 1'b1, rcmp_pkg::SIZE_BYTE,
                  16'h00fe);
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_RADDR), 1'b0, rcmp_pkg::SIZE_HALF,
                  16'hffff);
      for (i = 0; i < 3; i++)
         send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_DATA), 1'b0, rcmp_pkg::SIZE_BYTE,
                     16'h0000);
      // Only the exact command value is accepted; a half word with a high bit fails.
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_CMD), 1'b1, rcmp_pkg::SIZE_HALF,
                  16'h00ff);
      send_access(reg_offset(WIN_OVERLAY, rcmp_pkg::WORD_CMD), 1'b1, rcmp_pkg::SIZE_HALF,
                  16'h01ff);
      send_access(reg_offset(WIN_OVERLAY, rcmp_pkg::WORD_CMD), 1'b0, rcmp_pkg::SIZE_BYTE,
                  16'h0000);
      send_access(reg_offset(WIN_OVERLAY, rcmp_pkg::WORD_WADDR), 1'b1, rcmp_pkg::SIZE_HALF,
                  16'hffff);
      send_access(reg_offset(WIN_OVERLAY, rcmp_pkg::WORD_RADDR), 1'b1, rcmp_pkg::SIZE_HALF,
                  16'h0013);
      // High offsets take writes and reject reads.
      send_access(8'hfc, 1'b1, rcmp_pkg::SIZE_HALF, 16'h5a5a);
      send_access(rcmp_pkg::HIGH_OFFSET, 1'b0, rcmp_pkg::SIZE_BYTE, 16'h0000);
      // Misaligned offsets and sizes other than byte or half word fail.
      send_access(8'hff, 1'b0, rcmp_pkg::SIZE_BYTE, 16'h0000);
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_WADDR), 1'b0, 3'd0, 16'h0000);
      send_access(reg_offset(WIN_PALETTE, rcmp_pkg::WORD_DATA), 1'b1, 3'd7, 16'hffff);
      wait_drained();

      words_sent = 0;
      next_drain = DRAIN_EVERY;
      while (words_sent - ignored_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         w = 1'($urandom_range(0, 1));
         if (pick < 30) begin
            if ($urandom_range(0, 3) != 0)
               send_access(reg_offset(w, rcmp_pkg::WORD_WADDR), 1'b1, pick_size(),
                           16'($urandom));
            c = rand_color();
            for (i = 0; i < 3; i++)
               send_access(reg_offset(w, rcmp_pkg::WORD_DATA), 1'b1, pick_size(),
                           with_byte(c[8*i +: 8]));
         end else if (pick < 55) begin
            // Readback sometimes aims at an entry that was recently uploaded.
            if ($urandom_range(0, 2) != 0) begin
               d = $urandom_range(0, 1) ? {8'($urandom), last_upload[w]} : 16'($urandom);
               send_access(reg_offset(w, rcmp_pkg::WORD_RADDR), 1'b1, pick_size(), d);
            end
            for (i = 0; i < 3; i++)
               send_access(reg_offset(w, rcmp_pkg::WORD_DATA), 1'b0, pick_size(),
                           16'($urandom));
         end else if (pick < 65) begin
            d = 16'($urandom);
            c = rand_color();
            for (rep = 0; rep < 2; rep++) begin
               send_access(reg_offset(w, rcmp_pkg::WORD_WADDR), 1'b1, rcmp_pkg::SIZE_HALF, d);
               for (i = 0; i < 3; i++)
                  send_access(reg_offset(w, rcmp_pkg::WORD_DATA), 1'b1, pick_size(),
                              with_byte(c[8*i +: 8]));
            end
         end else if (pick < 80) begin
            word = 2'($urandom_range(0, 3));
            wr = 1'($urandom_range(0, 1));
            d = (word == rcmp_pkg::WORD_CMD && $urandom_range(0, 1)) ?
                with_byte(rcmp_pkg::CMD_VALUE) : 16'($urandom);
            send_access(reg_offset(w, word), wr, pick_size(), d);
         end else if (pick < 88) begin
            // A transfer cut short after one or two bytes.
            wr = 1'($urandom_range(0, 1));
            rep = $urandom_range(1, 2);
            for (i = 0; i < rep; i++)
               send_access(reg_offset(w, rcmp_pkg::WORD_DATA), wr, pick_size(),
                           16'($urandom));
         end else begin
            send_access(8'($urandom), 1'($urandom), 3'($urandom), 16'($urandom));
            ignored_words++;
         end
         if (words_sent >= next_drain) begin
            wait_drained();
            next_drain += DRAIN_EVERY;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d result words for %0d accesses: %0d bus errors, %0d color bytes read,",
               sb.results, sb.accesses, sb.bus_errors, sb.read_bytes);
      $display("%0d table entries changed, %0d mismatches.", sb.changes, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ramdac_color_map_port_core_tb: PASS");
      else
         $display("ramdac_color_map_port_core_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
